// ===== rtl/bcc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bcc_pkg
// Shared constants, codes and types of the button click classifier.
// ----------------------------------------------------------------------------
package bcc_pkg;

  localparam int NUM_PINS    = 8;
  localparam int NUM_KEYS    = NUM_PINS + 1;
  localparam int COUNT_WIDTH = 16;
  localparam int KEY_W       = 4;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 16;

  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

  // debounce counter reset, half the reset filter length
  localparam logic [COUNT_WIDTH-1:0] CNT_RESET = COUNT_WIDTH'(5 / 2);

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_LEVELS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FILTER_TICKS  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_TICKS    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DOUBLE_TICKS  = 3'd3;

  typedef enum logic [1:0] {
    EV_SINGLE   = 2'd0,
    EV_LONG     = 2'd1,
    EV_DOUBLE   = 2'd2,
    EV_LONG_REL = 2'd3
  } ev_kind_t;

  typedef struct packed {
    logic [7:0]  active_levels;
    logic [7:0]  filter_ticks;
    logic [15:0] long_ticks;
    logic [15:0] double_ticks;
  } cfg_t;

  typedef struct packed {
    logic     valid;
    ev_kind_t kind;
  } ev_t;

endpackage : bcc_pkg
`default_nettype wire

// ===== rtl/button_click_classifier.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// button_click_classifier
// Debounces eight button pins plus a combo key and reports click events.
// ----------------------------------------------------------------------------
// Each accepted input beat is one tick of raw pin levels. Nine key lanes
// (eight pins and the combo key formed by keys 0 and 1 together) update
// their debounce and press state in the cycle the tick is taken; the events
// found are then sent out in key order, one result beat per cycle while the
// receiver does not stall, with out_last_event marking the final event of
// the tick. The events drain through the single output register of the
// merge stage. in_stall is high while events of the previous tick are still
// held. Configuration writes are always ready and take effect on the next
// tick.
// ----------------------------------------------------------------------------
module button_click_classifier (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // tick input
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic [bcc_pkg::NUM_PINS-1:0]      in_pin_levels,
  // event output
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic [bcc_pkg::KEY_W-1:0]              out_key_index,
  output logic [1:0]                             out_event_kind,
  output logic                                   out_last_event,
  // register writes
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [bcc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [bcc_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import bcc_pkg::*;

  cfg_t                 cfg_r;
  logic                 busy;
  logic                 step;
  logic [NUM_PINS-1:0]  active;
  logic [NUM_KEYS-1:0]  down;
  ev_t [NUM_KEYS-1:0]   ev;

  // register file, writes always taken
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.active_levels <= 8'd0;
      cfg_r.filter_ticks  <= 8'd5;
      cfg_r.long_ticks    <= 16'd100;
      cfg_r.double_ticks  <= 16'd30;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_ACTIVE_LEVELS: cfg_r.active_levels <= cfg_data[7:0];
        CFG_FILTER_TICKS:  cfg_r.filter_ticks  <= cfg_data[7:0];
        CFG_LONG_TICKS:    cfg_r.long_ticks    <= cfg_data[15:0];
        CFG_DOUBLE_TICKS:  cfg_r.double_ticks  <= cfg_data[15:0];
        default: begin
        end
      endcase
    end
  end

  // one tick at a time: hold off while events are still draining
  assign in_stall = busy;
  assign step     = in_valid && !busy;

  // pins matching their active level
  assign active = ~(in_pin_levels ^ cfg_r.active_levels[NUM_PINS-1:0]);

  // a hard key is pressed only when it is the sole active key
  always_comb begin
    for (int k = 0; k < NUM_PINS; k++) begin
      down[k] = (active == (NUM_PINS'(1) << k));
    end
    // combo key, keys 0 and 1 both active
    down[NUM_PINS] = active[0] && active[1];
  end

  for (genvar k = 0; k < NUM_KEYS; k++) begin : g_lane
    bcc_lane u_lane (
      .clk   (clk),
      .rst_n (rst_n),
      .step  (step),
      .down  (down[k]),
      .cfg   (cfg_r),
      .ev    (ev[k])
    );
  end

  // collects the lane events and drains them in key order
  bcc_merge u_merge (
    .clk            (clk),
    .rst_n          (rst_n),
    .load           (step),
    .ev_in          (ev),
    .busy           (busy),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_key_index  (out_key_index),
    .out_event_kind (out_event_kind),
    .out_last_event (out_last_event)
  );

endmodule : button_click_classifier
`default_nettype wire

// ===== rtl/bcc_lane.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bcc_lane
// One key: debounce counter, press state machine and click timing.
// ----------------------------------------------------------------------------
module bcc_lane (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         step,
  input  wire logic         down,
  input  wire bcc_pkg::cfg_t cfg,
  output bcc_pkg::ev_t      ev
);
  import bcc_pkg::*;

  typedef enum logic [2:0] {
    ST_RELEASED  = 3'b001,
    ST_PRESSED   = 3'b010,
    ST_LONG_HELD = 3'b100
  } press_state_t;

  press_state_t           state_r, state_nxt;
  logic [COUNT_WIDTH-1:0] cnt_r, cnt_nxt;
  logic [COUNT_WIDTH-1:0] since_r, since_nxt;
  logic                   pend_r, pend_nxt;

  logic [COUNT_WIDTH-1:0] filt, filt2, long_t, dbl_t, since_inc, cnt_inc;

  assign filt      = COUNT_WIDTH'(cfg.filter_ticks);
  assign filt2     = COUNT_WIDTH'({cfg.filter_ticks, 1'b0});
  assign long_t    = COUNT_WIDTH'(cfg.long_ticks);
  assign dbl_t     = COUNT_WIDTH'(cfg.double_ticks);
  assign since_inc = (since_r == CNT_MAX) ? since_r : since_r + 1'b1;
  assign cnt_inc   = (cnt_r == CNT_MAX) ? cnt_r : cnt_r + 1'b1;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    since_nxt = since_inc;
    pend_nxt  = pend_r;
    ev.valid  = 1'b0;
    ev.kind   = EV_SINGLE;
    if (down) begin
      if (cnt_r < filt) begin
        cnt_nxt = filt;
      end else if (cnt_r < filt2) begin
        cnt_nxt = cnt_r + 1'b1;
      end else begin
        cnt_nxt = cnt_inc;
        if (state_r == ST_RELEASED) begin
          state_nxt = ST_PRESSED;
        end
        if ((cnt_inc > long_t) && (state_r != ST_LONG_HELD)) begin
          state_nxt = ST_LONG_HELD;
          ev.valid  = 1'b1;
          ev.kind   = EV_LONG;
        end
      end
    end else begin
      if (cnt_r > filt) begin
        cnt_nxt = filt;
      end else if (cnt_r != '0) begin
        cnt_nxt = cnt_r - 1'b1;
      end else begin
        case (state_r)
          ST_LONG_HELD: begin
            state_nxt = ST_RELEASED;
            ev.valid  = 1'b1;
            ev.kind   = EV_LONG_REL;
          end
          ST_PRESSED: begin
            state_nxt = ST_RELEASED;
            if (!pend_r) begin
              pend_nxt  = 1'b1;
              since_nxt = '0;
            end else if (since_inc < dbl_t) begin
              pend_nxt = 1'b0;
              ev.valid = 1'b1;
              ev.kind  = EV_DOUBLE;
            end
          end
          default: begin
            if (pend_r && (since_inc > dbl_t)) begin
              pend_nxt = 1'b0;
              ev.valid = 1'b1;
              ev.kind  = EV_SINGLE;
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_RELEASED;
      cnt_r   <= CNT_RESET;
      since_r <= '0;
      pend_r  <= 1'b0;
    end else if (step) begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      since_r <= since_nxt;
      pend_r  <= pend_nxt;
    end
  end

endmodule : bcc_lane
`default_nettype wire

// ===== rtl/bcc_merge.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bcc_merge
// Holds the events of one tick and sends them out in key order, one a beat.
// ----------------------------------------------------------------------------
module bcc_merge (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire logic                                   load,
  input  wire bcc_pkg::ev_t [bcc_pkg::NUM_KEYS-1:0]   ev_in,
  output logic                                        busy,
  output logic                                        out_valid,
  input  wire logic                                   out_stall,
  output logic [bcc_pkg::KEY_W-1:0]                   out_key_index,
  output logic [1:0]                                  out_event_kind,
  output logic                                        out_last_event
);
  import bcc_pkg::*;

  logic [NUM_KEYS-1:0]  pend_r, pend_nxt;
  ev_kind_t             kind_r [NUM_KEYS];
  logic                 out_valid_r, out_valid_nxt;
  logic [KEY_W-1:0]     out_key_r;
  ev_kind_t             out_kind_r;
  logic                 out_last_r;

  logic [NUM_KEYS-1:0]  sel_onehot;
  logic [KEY_W-1:0]     sel_idx;
  logic                 advance;

  assign sel_onehot = pend_r & (~pend_r + 1'b1);
  assign advance    = (!out_valid_r || !out_stall) && (pend_r != '0);

  always_comb begin
    sel_idx = '0;
    for (int i = 0; i < NUM_KEYS; i++) begin
      if (sel_onehot[i]) begin
        sel_idx = KEY_W'(i);
      end
    end
  end

  always_comb begin
    pend_nxt      = pend_r;
    out_valid_nxt = out_valid_r;
    if (load) begin
      for (int i = 0; i < NUM_KEYS; i++) begin
        pend_nxt[i] = ev_in[i].valid;
      end
    end else if (advance) begin
      pend_nxt      = pend_r & ~sel_onehot;
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      for (int i = 0; i < NUM_KEYS; i++) begin
        kind_r[i] <= ev_in[i].kind;
      end
    end
    if (advance && !load) begin
      out_key_r  <= sel_idx;
      out_kind_r <= kind_r[sel_idx];
      out_last_r <= ((pend_r & ~sel_onehot) == '0);
    end
  end

  assign busy           = (pend_r != '0) || out_valid_r;
  assign out_valid      = out_valid_r;
  assign out_key_index  = out_key_r;
  assign out_event_kind = out_kind_r;
  assign out_last_event = out_last_r;

endmodule : bcc_merge
`default_nettype wire
